// File: hw/rtl/sexp_pkg.sv
// Shared types, character codes and the front-to-back command record of the tokenizer.
package sexp_pkg;

  localparam int SEXP_MAX_DEPTH   = 255;
  localparam int SEXP_LINE_BITS   = 24;
  localparam int SEXP_QUEUE_DEPTH = 4;

  localparam int CP_BITS    = 21;
  localparam int BYTE_SLOTS = 7;               // most content bytes one code point can cause
  localparam int SLOT_COUNT = BYTE_SLOTS + 2;  // atom end, main event, content bytes

  // Result event codes
  typedef enum logic [2:0] {
    EV_OPEN  = 3'd0,
    EV_CLOSE = 3'd1,
    EV_START = 3'd2,
    EV_BYTE  = 3'd3,
    EV_END   = 3'd4,
    EV_ERROR = 3'd5
  } event_kind_t;

  // Non-byte event carried by a command besides an atom end
  typedef enum logic [2:0] {
    MAIN_NONE  = 3'd0,
    MAIN_OPEN  = 3'd1,
    MAIN_CLOSE = 3'd2,
    MAIN_START = 3'd3,
    MAIN_ERROR = 3'd4
  } main_kind_t;

  localparam logic FAULT_UNBALANCED = 1'b0;
  localparam logic FAULT_OVERFLOW   = 1'b1;

  // Lexer states
  typedef enum logic [3:0] {
    LEX_IDLE     = 4'd0,
    LEX_COMMENT  = 4'd1,
    LEX_PLAIN    = 4'd2,
    LEX_QUOTED   = 4'd3,
    LEX_ESC      = 4'd4,
    LEX_OCT      = 4'd5,
    LEX_HEX      = 4'd6,
    LEX_UNI      = 4'd7,
    LEX_PEND_END = 4'd8
  } lex_state_t;

  // Internal atom kind; output atom type is this minus one
  localparam logic [1:0] ATOM_NONE   = 2'd0;
  localparam logic [1:0] ATOM_PLAIN  = 2'd1;
  localparam logic [1:0] ATOM_SINGLE = 2'd2;
  localparam logic [1:0] ATOM_DOUBLE = 2'd3;

  localparam logic [CP_BITS-1:0] CP_TAB    = 21'h09;
  localparam logic [CP_BITS-1:0] CP_LF     = 21'h0A;
  localparam logic [CP_BITS-1:0] CP_VT     = 21'h0B;
  localparam logic [CP_BITS-1:0] CP_CR     = 21'h0D;
  localparam logic [CP_BITS-1:0] CP_SPACE  = 21'h20;
  localparam logic [CP_BITS-1:0] CP_DQUOTE = 21'h22;
  localparam logic [CP_BITS-1:0] CP_SQUOTE = 21'h27;
  localparam logic [CP_BITS-1:0] CP_LPAREN = 21'h28;
  localparam logic [CP_BITS-1:0] CP_RPAREN = 21'h29;
  localparam logic [CP_BITS-1:0] CP_ZERO   = 21'h30;
  localparam logic [CP_BITS-1:0] CP_SEVEN  = 21'h37;
  localparam logic [CP_BITS-1:0] CP_NINE   = 21'h39;
  localparam logic [CP_BITS-1:0] CP_SEMI   = 21'h3B;
  localparam logic [CP_BITS-1:0] CP_BSLASH = 21'h5C;
  localparam logic [CP_BITS-1:0] CP_LC_A   = 21'h61;
  localparam logic [CP_BITS-1:0] CP_LC_B   = 21'h62;
  localparam logic [CP_BITS-1:0] CP_LC_F   = 21'h66;
  localparam logic [CP_BITS-1:0] CP_LC_N   = 21'h6E;
  localparam logic [CP_BITS-1:0] CP_LC_R   = 21'h72;
  localparam logic [CP_BITS-1:0] CP_LC_T   = 21'h74;
  localparam logic [CP_BITS-1:0] CP_LC_U   = 21'h75;
  localparam logic [CP_BITS-1:0] CP_LC_V   = 21'h76;
  localparam logic [CP_BITS-1:0] CP_LC_X   = 21'h78;

  localparam logic [7:0] BYTE_BEL    = 8'd7;
  localparam logic [7:0] BYTE_BS     = 8'd8;
  localparam logic [7:0] BYTE_TAB    = 8'd9;
  localparam logic [7:0] BYTE_LF     = 8'd10;
  localparam logic [7:0] BYTE_VT     = 8'd11;
  localparam logic [7:0] BYTE_FF     = 8'd12;
  localparam logic [7:0] BYTE_CR     = 8'd13;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_LC_U   = 8'h75;
  localparam logic [7:0] BYTE_LC_X   = 8'h78;

  // Everything one code point causes, in output order: end, main, bytes
  typedef struct packed {
    logic                          end_valid;
    logic [1:0]                    end_type;
    logic [23:0]                   end_line;
    logic [7:0]                    end_nest;
    main_kind_t                    main_kind;
    logic                          fault;
    logic [2:0]                    byte_count;
    logic [BYTE_SLOTS-1:0][7:0]    bytes;
    logic [1:0]                    body_type;
    logic [23:0]                   body_line;
    logic [7:0]                    body_nest;
  } sexp_cmd_t;

endpackage

// File: hw/rtl/sexp_if.sv
// Valid/ready channel interfaces for code points in and token events out.
interface sexp_cp_if import sexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CP_BITS-1:0] code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

interface sexp_ev_if import sexp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [1:0]  atom_type;
  logic [7:0]  data_byte;
  logic [23:0] start_line;
  logic [7:0]  nest_level;
  logic [0:0]  fault_code;
  logic        last;

  modport source (output valid, output event_kind, output atom_type, output data_byte,
                  output start_line, output nest_level, output fault_code, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input atom_type, input data_byte,
                  input start_line, input nest_level, input fault_code, input last,
                  output ready);
endinterface

// File: hw/rtl/s_expression_tokenizer_core.sv
// S-expression tokenizer top level: code points in, token events out.
// Throughput: one code point per cycle while each causes at most one event and the sink
//   is ready; a code point causing n events holds the event sequencer until all n are
//   sent, bursts absorbed by the queue. Path: a code point's first event passes a queue
//   slot, then the output register; later ones follow one per cycle while the sink is ready.
// Reset (rst, synchronous): lexer to idle, depth 0, line 1, error cleared, queue and
//   output register emptied; ready is low during reset and rises in the first cycle after.
module s_expression_tokenizer_core import sexp_pkg::*; #(
  parameter int MAX_DEPTH   = SEXP_MAX_DEPTH,
  parameter int LINE_BITS   = SEXP_LINE_BITS,
  parameter int QUEUE_DEPTH = SEXP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  sexp_cp_if.sink   text,
  sexp_ev_if.source tokens
);

  // Front end: full lexer step per request; ready drops when the queue is full or in reset.
  // Code point zero, and everything after a sticky error, is taken and dropped here.
  logic      q_push;
  logic      q_full;
  sexp_cmd_t q_wdata;

  // Back end: one event per cycle while the sink is ready, queue head to output register.
  logic      q_pop;
  logic      q_valid;
  sexp_cmd_t q_rdata;

  sexp_front #(
    .MAX_DEPTH (MAX_DEPTH),
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .full (q_full),
    .push (q_push),
    .cmd  (q_wdata)
  );

  // Commands carry all events of one code point (atom end, main event, up to 7 bytes)
  sexp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // The output register lets the next event load in the cycle the current one is taken
  sexp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_rdata),
    .pop        (q_pop),
    .tokens     (tokens)
  );

endmodule

// File: hw/rtl/sexp_front.sv
// Lexer front end: one code point a cycle while the queue has room; a command if any events.
module sexp_front import sexp_pkg::*; #(
  parameter int MAX_DEPTH = SEXP_MAX_DEPTH,
  parameter int LINE_BITS = SEXP_LINE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  sexp_cp_if.sink   text,
  input  logic      full,
  output logic      push,
  output sexp_cmd_t cmd
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef struct packed {
    logic [2:0]                 n;
    logic [BYTE_SLOTS-1:0][7:0] b;
  } byte_list_t;

  function automatic byte_list_t add_byte(input byte_list_t ol, input logic [7:0] x);
    byte_list_t r;
    r = ol;
    if (r.n != 3'(BYTE_SLOTS)) begin
      r.b[r.n] = x;
      r.n      = r.n + 3'd1;
    end
    return r;
  endfunction

  // UTF-8 of a 21-bit value, four-byte form above 0xFFFF
  function automatic byte_list_t add_cp(input byte_list_t ol, input logic [CP_BITS-1:0] v);
    byte_list_t r;
    r = ol;
    if (v < 21'h80) begin
      r = add_byte(r, {1'b0, v[6:0]});
    end else if (v < 21'h800) begin
      r = add_byte(r, {3'b110, v[10:6]});
      r = add_byte(r, {2'b10, v[5:0]});
    end else if (v < 21'h10000) begin
      r = add_byte(r, {4'b1110, v[15:12]});
      r = add_byte(r, {2'b10, v[11:6]});
      r = add_byte(r, {2'b10, v[5:0]});
    end else begin
      r = add_byte(r, {5'b11110, v[20:18]});
      r = add_byte(r, {2'b10, v[17:12]});
      r = add_byte(r, {2'b10, v[11:6]});
      r = add_byte(r, {2'b10, v[5:0]});
    end
    return r;
  endfunction

  function automatic logic [15:0] digits_value(input logic [3:0][3:0] dg,
                                               input logic [2:0] cnt, input logic four);
    logic [15:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < cnt) v = four ? {v[11:0], dg[k]} : {v[12:0], dg[k][2:0]};
    end
    return v;
  endfunction

  function automatic logic [1:0] type_out(input logic [1:0] ak);
    return (ak != ATOM_NONE) ? ak - 2'd1 : 2'd0;
  endfunction

  function automatic logic [23:0] line_out(input logic [LINE_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    if (w > 32'h00FF_FFFF) return 24'hFF_FFFF;
    return w[23:0];
  endfunction

  function automatic logic [7:0] nest_out(input logic [DW-1:0] d);
    logic [31:0] w;
    w = 32'(d);
    return w[7:0];
  endfunction

  lex_state_t           state, state_next;
  logic                 quote_dbl, quote_dbl_next;
  logic [1:0]           atom_kind, atom_kind_next;
  logic [3:0][3:0]      digits, digits_next;
  logic [2:0]           digit_count, digit_count_next;
  logic [DW-1:0]        depth, depth_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [LINE_BITS-1:0] atom_line, atom_line_next;
  logic                 error, error_next;

  logic [CP_BITS-1:0]   c;
  logic                 active;
  logic                 has_events;

  assign c          = text.code_point;
  assign text.ready = !full && !rst;
  assign active     = text.valid && text.ready && (c != '0) && !error;
  assign push       = active && has_events;

  always_comb begin : lex_step
    lex_state_t           st;
    logic                 qd;
    logic [1:0]           ak;
    logic [3:0][3:0]      dg;
    logic [2:0]           dc;
    logic [DW-1:0]        dep;
    logic [LINE_BITS-1:0] ln;
    logic [LINE_BITS-1:0] al;
    logic                 err;
    logic                 redo;
    logic                 white;
    logic                 octd;
    logic                 hexd;
    logic [3:0]           hv;
    logic [15:0]          dv;
    logic                 uni;
    logic [2:0]           need;
    byte_list_t           ol;
    main_kind_t           mk;
    logic                 fc;
    logic                 endv;
    logic [1:0]           endt;
    logic [LINE_BITS-1:0] endl;
    logic [DW-1:0]        endd;

    st   = state;
    qd   = quote_dbl;
    ak   = atom_kind;
    dg   = digits;
    dc   = digit_count;
    dep  = depth;
    al   = atom_line;
    err  = error;
    redo = 1'b1;
    ol   = '0;
    mk   = MAIN_NONE;
    fc   = FAULT_UNBALANCED;
    endv = 1'b0;
    endt = 2'd0;
    endl = atom_line;
    endd = depth;
    dv   = '0;
    uni  = 1'b0;
    need = 3'd0;

    ln = ((c == CP_LF) && (line != '1)) ? line + LINE_BITS'(1) : line;

    white = (c == CP_SPACE) || (c == CP_LF) || (c == CP_CR) || (c == CP_TAB) || (c == CP_VT);
    octd  = (c >= CP_ZERO) && (c <= CP_SEVEN);
    hexd  = ((c >= CP_ZERO) && (c <= CP_NINE)) || ((c >= CP_LC_A) && (c <= CP_LC_F));
    hv    = (c <= CP_NINE) ? c[3:0] : c[3:0] + 4'd9;

    // At most three passes: atom end, back to idle, start of a plain atom
    for (int p = 0; p < 3; p++) begin
      if (redo && !err) begin
        redo = 1'b0;
        case (st)
          LEX_COMMENT: begin
            if (c == CP_LF) st = LEX_IDLE;
          end
          LEX_PLAIN: begin
            if (white || (c == CP_LPAREN) || (c == CP_RPAREN) || (c == CP_DQUOTE) ||
                (c == CP_SQUOTE)) begin
              endv = 1'b1;
              endt = type_out(ak);
              endl = al;
              endd = dep;
              ak   = ATOM_NONE;
              st   = LEX_IDLE;
              redo = 1'b1;
            end else begin
              ol = add_cp(ol, c);
            end
          end
          LEX_QUOTED: begin
            if (c == (qd ? CP_DQUOTE : CP_SQUOTE)) begin
              st = LEX_PEND_END;
            end else if (qd && (c == CP_BSLASH)) begin
              st = LEX_ESC;
            end else begin
              ol = add_cp(ol, c);
            end
          end
          LEX_PEND_END: begin
            endv = 1'b1;
            endt = type_out(ak);
            endl = al;
            endd = dep;
            ak   = ATOM_NONE;
            st   = LEX_IDLE;
            redo = 1'b1;
          end
          LEX_ESC: begin
            st = LEX_QUOTED;
            if ((c == CP_BSLASH) || (c == CP_DQUOTE)) ol = add_byte(ol, c[7:0]);
            else if (c == CP_LC_A) ol = add_byte(ol, BYTE_BEL);
            else if (c == CP_LC_B) ol = add_byte(ol, BYTE_BS);
            else if (c == CP_LC_F) ol = add_byte(ol, BYTE_FF);
            else if (c == CP_LC_N) ol = add_byte(ol, BYTE_LF);
            else if (c == CP_LC_R) ol = add_byte(ol, BYTE_CR);
            else if (c == CP_LC_T) ol = add_byte(ol, BYTE_TAB);
            else if (c == CP_LC_V) ol = add_byte(ol, BYTE_VT);
            else if (octd) begin
              dc   = 3'd0;
              st   = LEX_OCT;
              redo = 1'b1;
            end else if (c == CP_LC_X) begin
              dc = 3'd0;
              st = LEX_HEX;
            end else if (c == CP_LC_U) begin
              dc = 3'd0;
              st = LEX_UNI;
            end else begin
              ol = add_byte(ol, BYTE_BSLASH);
              ol = add_cp(ol, c);
            end
          end
          LEX_OCT: begin
            if (octd && (dc < 3'd2)) begin
              dg[dc[1:0]] = {1'b0, c[2:0]};
              dc          = dc + 3'd1;
            end else if (octd && (dc == 3'd2) && (dg[0] <= 4'd3)) begin
              dg[2] = {1'b0, c[2:0]};
              dc    = 3'd3;
              dv    = digits_value(dg, dc, 1'b0);
              ol    = add_byte(ol, dv[7:0]);
              st    = LEX_QUOTED;
            end else begin
              dv = digits_value(dg, dc, 1'b0);
              if (dc != 3'd0) ol = add_byte(ol, dv[7:0]);
              else ol = add_byte(ol, BYTE_BSLASH);
              st   = LEX_QUOTED;
              redo = 1'b1;
            end
          end
          LEX_HEX, LEX_UNI: begin
            uni  = (st == LEX_UNI);
            need = uni ? 3'd4 : 3'd2;
            if (hexd && ((dc + 3'd1) < need)) begin
              dg[dc[1:0]] = hv;
              dc          = dc + 3'd1;
            end else if (hexd && ((dc + 3'd1) == need)) begin
              dg[dc[1:0]] = hv;
              dc          = dc + 3'd1;
              dv          = digits_value(dg, dc, 1'b1);
              if (uni) ol = add_cp(ol, CP_BITS'(dv));
              else ol = add_byte(ol, dv[7:0]);
              st = LEX_QUOTED;
            end else begin
              dv = digits_value(dg, dc, 1'b1);
              if (dc != 3'd0) begin
                if (uni) ol = add_cp(ol, CP_BITS'(dv));
                else ol = add_byte(ol, dv[7:0]);
              end else begin
                ol = add_byte(ol, BYTE_BSLASH);
                ol = add_byte(ol, uni ? BYTE_LC_U : BYTE_LC_X);
              end
              st   = LEX_QUOTED;
              redo = 1'b1;
            end
          end
          default: begin
            st = LEX_IDLE;
            if (white) begin
              st = LEX_IDLE;
            end else if (c == CP_SEMI) begin
              st = LEX_COMMENT;
            end else if (c == CP_LPAREN) begin
              if (dep >= DW'(MAX_DEPTH)) begin
                mk  = MAIN_ERROR;
                fc  = FAULT_OVERFLOW;
                err = 1'b1;
              end else begin
                dep = dep + DW'(1);
                mk  = MAIN_OPEN;
              end
            end else if (c == CP_RPAREN) begin
              if (dep == '0) begin
                mk  = MAIN_ERROR;
                fc  = FAULT_UNBALANCED;
                err = 1'b1;
              end else begin
                dep = dep - DW'(1);
                mk  = MAIN_CLOSE;
              end
            end else begin
              al = ln;
              mk = MAIN_START;
              if ((c == CP_DQUOTE) || (c == CP_SQUOTE)) begin
                qd = (c == CP_DQUOTE);
                ak = qd ? ATOM_DOUBLE : ATOM_SINGLE;
                st = LEX_QUOTED;
              end else begin
                ak   = ATOM_PLAIN;
                st   = LEX_PLAIN;
                redo = 1'b1;
              end
            end
          end
        endcase
      end
    end

    state_next       = st;
    quote_dbl_next   = qd;
    atom_kind_next   = ak;
    digits_next      = dg;
    digit_count_next = dc;
    depth_next       = dep;
    line_next        = ln;
    atom_line_next   = al;
    error_next       = err;

    has_events = endv || (mk != MAIN_NONE) || (ol.n != 3'd0);

    cmd.end_valid  = endv;
    cmd.end_type   = endt;
    cmd.end_line   = line_out(endl);
    cmd.end_nest   = nest_out(endd);
    cmd.main_kind  = mk;
    cmd.fault      = fc;
    cmd.byte_count = ol.n;
    cmd.bytes      = ol.b;
    cmd.body_type  = type_out(ak);
    cmd.body_line  = line_out(al);
    cmd.body_nest  = nest_out(dep);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= LEX_IDLE;
      quote_dbl   <= 1'b0;
      atom_kind   <= ATOM_NONE;
      digit_count <= 3'd0;
      depth       <= '0;
      line        <= LINE_BITS'(1);
      atom_line   <= LINE_BITS'(1);
      error       <= 1'b0;
    end else if (active) begin
      state       <= state_next;
      quote_dbl   <= quote_dbl_next;
      atom_kind   <= atom_kind_next;
      digit_count <= digit_count_next;
      depth       <= depth_next;
      line        <= line_next;
      atom_line   <= atom_line_next;
      error       <= error_next;
    end
  end

  // escape digits are always written before they are read
  always_ff @(posedge clk) begin
    if (active) digits <= digits_next;
  end

endmodule

// File: hw/rtl/sexp_queue.sv
// Small command queue between the lexer front end and the event sequencer.
module sexp_queue import sexp_pkg::*; #(
  parameter int DEPTH = SEXP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  sexp_cmd_t wdata,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output sexp_cmd_t rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sexp_cmd_t       slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule

// File: hw/rtl/sexp_back.sv
// Event sequencer: registers a command's events out one per cycle while the sink is ready.
module sexp_back import sexp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  sexp_cmd_t head,
  output logic      pop,
  sexp_ev_if.source tokens
);

  logic [SLOT_COUNT-1:0] done;
  logic [SLOT_COUNT-1:0] present;
  logic [SLOT_COUNT-1:0] remaining;
  logic [SLOT_COUNT-1:0] cur;
  logic                  is_last;
  logic                  load;
  logic                  out_valid;

  event_kind_t ev_kind;
  logic [1:0]  ev_type;
  logic [7:0]  ev_data;
  logic [23:0] ev_line;
  logic [7:0]  ev_nest;
  logic        ev_fault;

  always_comb begin
    present[0] = head.end_valid;
    present[1] = (head.main_kind != MAIN_NONE);
    for (int i = 0; i < BYTE_SLOTS; i++) present[2 + i] = (3'(i) < head.byte_count);
    remaining = present & ~done;
    cur       = remaining & (~remaining + SLOT_COUNT'(1));
    is_last   = ((remaining & ~cur) == '0);
  end

  always_comb begin
    ev_kind  = EV_BYTE;
    ev_type  = head.body_type;
    ev_data  = 8'd0;
    ev_line  = head.body_line;
    ev_nest  = head.body_nest;
    ev_fault = 1'b0;
    for (int i = 0; i < BYTE_SLOTS; i++) begin
      if (cur[2 + i]) ev_data = head.bytes[i];
    end
    if (cur[0]) begin
      ev_kind = EV_END;
      ev_type = head.end_type;
      ev_line = head.end_line;
      ev_nest = head.end_nest;
    end else if (cur[1]) begin
      ev_type = 2'd0;
      ev_line = 24'd0;
      case (head.main_kind)
        MAIN_OPEN:  ev_kind = EV_OPEN;
        MAIN_CLOSE: ev_kind = EV_CLOSE;
        MAIN_ERROR: begin
          ev_kind  = EV_ERROR;
          ev_fault = head.fault;
        end
        MAIN_START: begin
          ev_kind = EV_START;
          ev_type = head.body_type;
          ev_line = head.body_line;
        end
        default:    ev_kind = EV_BYTE;
      endcase
    end
  end

  assign load         = head_valid && (!out_valid || tokens.ready);
  assign pop          = load && is_last;
  assign tokens.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      done      <= is_last ? '0 : (done | cur);
    end else if (tokens.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tokens.event_kind <= ev_kind;
      tokens.atom_type  <= ev_type;
      tokens.data_byte  <= ev_data;
      tokens.start_line <= ev_line;
      tokens.nest_level <= ev_nest;
      tokens.fault_code <= ev_fault;
      tokens.last       <= is_last;
    end
  end

endmodule

// File: sim/s_expression_tokenizer_core_test.sv
// Self-checking testbench for the S-expression tokenizer core.
`timescale 1ns / 100ps

module s_expression_tokenizer_core_test;
  import sexp_pkg::*;

  localparam int RANDOM_ITEMS    = 100;
  localparam int HOLD_CYCLES     = 200;      // long receiver hold-off for the backpressure test
  localparam int DRAIN_CYCLES    = 20;       // settle time after the last expected event
  localparam int MAX_STEP_EVENTS = 8;        // cap per code point; at most 7 can occur
  localparam int RUN_LIMIT_NS    = 10_000_000;

  // One expected token event, same fields as the output channel
  typedef struct packed {
    event_kind_t kind;
    logic [1:0]  atype;
    logic [7:0]  data;
    logic [23:0] line;
    logic [7:0]  nest;
    logic        fault;
    logic        last;
  } token_ev_t;

  logic clk;
  logic rst;

  sexp_cp_if cp_bus ();
  sexp_ev_if ev_bus ();

  s_expression_tokenizer_core dut (
    .clk    (clk),
    .rst    (rst),
    .text   (cp_bus),
    .tokens (ev_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Lexer mirror: own copy of everything the block tracks
  // ---------------------------------------------------------------------------
  lex_state_t  lex             = LEX_IDLE;
  logic        in_dquote       = 1'b0;
  logic [1:0]  atom_kind       = ATOM_NONE;
  logic [3:0]  esc_dig [4]     = '{4'd0, 4'd0, 4'd0, 4'd0};
  logic [2:0]  esc_cnt         = 3'd0;
  int          depth           = 0;
  logic [23:0] cur_line        = 24'd1;
  logic [23:0] atom_first_line = 24'd1;
  logic        halted          = 1'b0;   // sticky error seen

  token_ev_t step_events[$];      // events of the request being predicted
  token_ev_t expected_tokens[$];  // events still owed by the block, oldest first

  // Stimulus / sink controls
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  int hold_requests = 0;   // bumped by a test to ask the sink for a long hold-off
  int holds_served  = 0;
  int rx_wait       = 0;
  int mismatch_count = 0;
  int random_count   = 0;

  function automatic bit is_white(input logic [CP_BITS-1:0] c);
    return c == CP_SPACE || c == CP_LF || c == CP_CR || c == CP_TAB || c == CP_VT;
  endfunction

  function automatic bit is_delim(input logic [CP_BITS-1:0] c);
    return is_white(c) || c == CP_LPAREN || c == CP_RPAREN || c == CP_DQUOTE ||
           c == CP_SQUOTE;
  endfunction

  function automatic bit is_oct(input logic [CP_BITS-1:0] c);
    return c >= CP_ZERO && c <= CP_SEVEN;
  endfunction

  // Lowercase hex only; -1 for anything else
  function automatic int hex_digit(input logic [CP_BITS-1:0] c);
    if (c >= CP_ZERO && c <= CP_NINE) return int'(c - CP_ZERO);
    if (c >= CP_LC_A && c <= CP_LC_F) return int'(c - CP_LC_A) + 10;
    return -1;
  endfunction

  function automatic logic [31:0] digits_value(input int shift);
    logic [31:0] v;
    int k;
    v = '0;
    for (k = 0; k < esc_cnt && k < 4; k++) v = (v << shift) | esc_dig[k];
    return v;
  endfunction

  // Atom events carry type and start line; list/error events carry zeros there
  function automatic void add_event(input event_kind_t kind, input logic [7:0] data,
                                    input logic fault);
    token_ev_t ev;
    if (step_events.size() >= MAX_STEP_EVENTS) return;
    ev = '0;
    ev.kind  = kind;
    ev.data  = data;
    ev.nest  = depth[7:0];
    ev.fault = fault;
    if (kind == EV_START || kind == EV_BYTE || kind == EV_END) begin
      ev.atype = (atom_kind == ATOM_NONE) ? 2'd0 : atom_kind - 2'd1;
      ev.line  = atom_first_line;
    end
    step_events.push_back(ev);
  endfunction

  // UTF-8 encode; anything past 16 bits uses the four-byte pattern
  function automatic void put_cp(input logic [31:0] v);
    logic [20:0] c;
    c = v[20:0];
    if (c < 21'h80) begin
      add_event(EV_BYTE, c[7:0], 1'b0);
    end else if (c < 21'h800) begin
      add_event(EV_BYTE, 8'hC0 | c[10:6], 1'b0);
      add_event(EV_BYTE, 8'h80 | c[5:0], 1'b0);
    end else if (c < 21'h10000) begin
      add_event(EV_BYTE, 8'hE0 | c[15:12], 1'b0);
      add_event(EV_BYTE, 8'h80 | c[11:6], 1'b0);
      add_event(EV_BYTE, 8'h80 | c[5:0], 1'b0);
    end else begin
      add_event(EV_BYTE, 8'hF0 | c[20:18], 1'b0);
      add_event(EV_BYTE, 8'h80 | c[17:12], 1'b0);
      add_event(EV_BYTE, 8'h80 | c[11:6], 1'b0);
      add_event(EV_BYTE, 8'h80 | c[5:0], 1'b0);
    end
  endfunction

  // Hex escape gives one byte, unicode escape gives its UTF-8
  function automatic void flush_hex_escape();
    logic [31:0] val;
    val = digits_value(4);
    if (lex == LEX_UNI) put_cp(val);
    else add_event(EV_BYTE, val[7:0], 1'b0);
  endfunction

  function automatic void raise_fault(input logic code);
    add_event(EV_ERROR, 8'd0, code);
    halted = 1'b1;
  endfunction

  // One code point through the lexer. A terminator may be reprocessed in the
  // new state (atom end before a paren, short escape before its follower).
  function automatic void run_lexer(input logic [CP_BITS-1:0] c);
    bit          redo;
    int          guard;
    int          h;
    int          full;
    logic [31:0] val;
    redo  = 1'b1;
    guard = 0;
    while (redo && guard < 4 && !halted) begin
      guard++;
      redo = 1'b0;
      case (lex)
        LEX_COMMENT: begin
          if (c == CP_LF) lex = LEX_IDLE;
        end
        LEX_PLAIN: begin
          if (is_delim(c)) begin
            add_event(EV_END, 8'd0, 1'b0);
            atom_kind = ATOM_NONE;
            lex       = LEX_IDLE;
            redo      = 1'b1;
          end else begin
            put_cp(c);
          end
        end
        LEX_QUOTED: begin
          if (c == (in_dquote ? CP_DQUOTE : CP_SQUOTE)) lex = LEX_PEND_END;
          else if (in_dquote && c == CP_BSLASH) lex = LEX_ESC;
          else put_cp(c);
        end
        LEX_PEND_END: begin
          // closing quote seen last time; the end event waits for this code point
          add_event(EV_END, 8'd0, 1'b0);
          atom_kind = ATOM_NONE;
          lex       = LEX_IDLE;
          redo      = 1'b1;
        end
        LEX_ESC: begin
          lex = LEX_QUOTED;
          if (c == CP_BSLASH || c == CP_DQUOTE) put_cp(c);
          else if (c == CP_LC_A) add_event(EV_BYTE, BYTE_BEL, 1'b0);
          else if (c == CP_LC_B) add_event(EV_BYTE, BYTE_BS, 1'b0);
          else if (c == CP_LC_F) add_event(EV_BYTE, BYTE_FF, 1'b0);
          else if (c == CP_LC_N) add_event(EV_BYTE, BYTE_LF, 1'b0);
          else if (c == CP_LC_R) add_event(EV_BYTE, BYTE_CR, 1'b0);
          else if (c == CP_LC_T) add_event(EV_BYTE, BYTE_TAB, 1'b0);
          else if (c == CP_LC_V) add_event(EV_BYTE, BYTE_VT, 1'b0);
          else if (is_oct(c)) begin
            esc_cnt = 3'd0;
            lex     = LEX_OCT;
            redo    = 1'b1;
          end else if (c == CP_LC_X) begin
            esc_cnt = 3'd0;
            lex     = LEX_HEX;
          end else if (c == CP_LC_U) begin
            esc_cnt = 3'd0;
            lex     = LEX_UNI;
          end else begin
            // unknown escape keeps the backslash
            add_event(EV_BYTE, BYTE_BSLASH, 1'b0);
            put_cp(c);
          end
        end
        LEX_OCT: begin
          if (is_oct(c) && esc_cnt < 3'd2) begin
            esc_dig[esc_cnt[1:0]] = {1'b0, c[2:0]};
            esc_cnt++;
          end else if (is_oct(c) && esc_cnt == 3'd2 && esc_dig[0] <= 4'd3) begin
            esc_dig[2] = {1'b0, c[2:0]};
            esc_cnt    = 3'd3;
            val        = digits_value(3);
            add_event(EV_BYTE, val[7:0], 1'b0);
            lex = LEX_QUOTED;
          end else begin
            if (esc_cnt != 3'd0) begin
              val = digits_value(3);
              add_event(EV_BYTE, val[7:0], 1'b0);
            end else begin
              add_event(EV_BYTE, BYTE_BSLASH, 1'b0);
            end
            lex  = LEX_QUOTED;
            redo = 1'b1;
          end
        end
        LEX_HEX, LEX_UNI: begin
          full = (lex == LEX_UNI) ? 4 : 2;
          h    = hex_digit(c);
          if (h >= 0 && esc_cnt + 1 < full) begin
            esc_dig[esc_cnt[1:0]] = h[3:0];
            esc_cnt++;
          end else if (h >= 0 && esc_cnt + 1 == full) begin
            esc_dig[esc_cnt[1:0]] = h[3:0];
            esc_cnt++;
            flush_hex_escape();
            lex = LEX_QUOTED;
          end else begin
            if (esc_cnt != 3'd0) begin
              flush_hex_escape();
            end else begin
              // no digit at all: both characters come back
              add_event(EV_BYTE, BYTE_BSLASH, 1'b0);
              add_event(EV_BYTE, (lex == LEX_UNI) ? BYTE_LC_U : BYTE_LC_X, 1'b0);
            end
            lex  = LEX_QUOTED;
            redo = 1'b1;
          end
        end
        default: begin
          lex = LEX_IDLE;
          if (!is_white(c)) begin
            if (c == CP_SEMI) begin
              lex = LEX_COMMENT;
            end else if (c == CP_LPAREN) begin
              if (depth >= SEXP_MAX_DEPTH) begin
                raise_fault(FAULT_OVERFLOW);
              end else begin
                depth++;
                add_event(EV_OPEN, 8'd0, 1'b0);
              end
            end else if (c == CP_RPAREN) begin
              if (depth == 0) begin
                raise_fault(FAULT_UNBALANCED);
              end else begin
                depth--;
                add_event(EV_CLOSE, 8'd0, 1'b0);
              end
            end else begin
              atom_first_line = cur_line;
              if (c == CP_DQUOTE || c == CP_SQUOTE) begin
                in_dquote = (c == CP_DQUOTE);
                atom_kind = in_dquote ? ATOM_DOUBLE : ATOM_SINGLE;
                add_event(EV_START, 8'd0, 1'b0);
                lex = LEX_QUOTED;
              end else begin
                // plain atom: this code point is its first content
                atom_kind = ATOM_PLAIN;
                add_event(EV_START, 8'd0, 1'b0);
                lex  = LEX_PLAIN;
                redo = 1'b1;
              end
            end
          end
        end
      endcase
    end
  endfunction

  // Predict everything one accepted request causes and queue it up
  function automatic void tokenize_cp(input logic [CP_BITS-1:0] c);
    token_ev_t ev;
    step_events.delete();
    if (c == '0 || halted) return;
    if (c == CP_LF && cur_line != '1) cur_line++;   // line count saturates
    run_lexer(c);
    if (step_events.size() != 0) begin
      ev      = step_events.pop_back();
      ev.last = 1'b1;
      step_events.push_back(ev);
    end
    foreach (step_events[i]) expected_tokens.push_back(step_events[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  // Spread over every UTF-8 length plus single-bit walks
  function automatic logic [CP_BITS-1:0] any_cp();
    case ($urandom_range(9))
      0, 1, 2, 3: return CP_BITS'($urandom_range(8'h7E, 8'h21));
      4:          return CP_BITS'($urandom_range(8'h1F, 8'h01));
      5:          return CP_BITS'($urandom_range(12'h7FF, 8'h80));
      6:          return CP_BITS'($urandom_range(16'hFFFF, 12'h800));
      7:          return CP_BITS'($urandom_range(21'h10FFFF, 17'h10000));
      8:          return CP_BITS'($urandom_range(21'h10FFFF, 0));
      default:    return 21'h1 << $urandom_range(20);
    endcase
  endfunction

  function automatic logic [CP_BITS-1:0] plain_cp();
    logic [CP_BITS-1:0] c;
    do c = any_cp(); while (is_delim(c));
    return c;
  endfunction

  // Quoted content that neither closes the atom nor starts an escape
  function automatic logic [CP_BITS-1:0] text_cp(input bit dq);
    logic [CP_BITS-1:0] c;
    do c = any_cp(); while (c == (dq ? CP_DQUOTE : CP_SQUOTE) || (dq && c == CP_BSLASH));
    return c;
  endfunction

  function automatic logic [CP_BITS-1:0] white_cp();
    case ($urandom_range(4))
      0:       return CP_SPACE;
      1:       return CP_LF;
      2:       return CP_CR;
      3:       return CP_TAB;
      default: return CP_VT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // valid is only lowered when a gap is taken, so back-to-back requests keep it high
  task automatic send_cp(input logic [CP_BITS-1:0] cp);
    int gap;
    gap = tx_idle_on ? idle_gap() : 0;
    if (gap > 0) begin
      cp_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cp_bus.valid      <= 1'b1;
    cp_bus.code_point <= cp;
    do @(posedge clk); while (!cp_bus.ready);
    tokenize_cp(cp);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_cp({13'b0, s[i]});
  endtask

  // Random phase only: a paren that would trip the sticky error becomes a space,
  // so the error is saved for the last test
  task automatic send_guarded(input logic [CP_BITS-1:0] cp);
    logic [CP_BITS-1:0] c;
    c = cp;
    if ((lex == LEX_IDLE || lex == LEX_PLAIN || lex == LEX_PEND_END) &&
        ((c == CP_RPAREN && depth == 0) ||
         (c == CP_LPAREN && depth >= SEXP_MAX_DEPTH)))
      c = CP_SPACE;
    if (c != '0) random_count++;
    send_cp(c);
  endtask

  task automatic send_escape();
    int    n;
    int    i;
    string simple = "\\\"abfnrtv";
    string hexd   = "0123456789abcdef";
    send_guarded(CP_BSLASH);
    case ($urandom_range(4))
      0: send_guarded({13'b0, simple[$urandom_range(8)]});
      1: begin
        n = $urandom_range(3, 1);
        for (i = 0; i < n; i++) send_guarded(CP_BITS'(CP_ZERO + $urandom_range(7)));
      end
      2: begin
        send_guarded(CP_LC_X);
        n = $urandom_range(2);
        for (i = 0; i < n; i++) send_guarded({13'b0, hexd[$urandom_range(15)]});
      end
      3: begin
        send_guarded(CP_LC_U);
        n = $urandom_range(4);
        for (i = 0; i < n; i++) send_guarded({13'b0, hexd[$urandom_range(15)]});
      end
      default: send_guarded(text_cp(1'b1));
    endcase
  endtask

  // One well-formed token with random content, or a bit of noise
  task automatic send_random_token();
    int r;
    int n;
    int i;
    logic [CP_BITS-1:0] c;
    r = $urandom_range(99);
    if (r < 12) begin
      send_guarded(any_cp());
    end else if (r < 27) begin
      send_guarded((depth == 0 || $urandom_range(1)) ? CP_LPAREN : CP_RPAREN);
    end else if (r < 37) begin
      send_guarded(white_cp());
    end else if (r < 45) begin
      send_guarded(CP_SEMI);
      n = $urandom_range(4);
      for (i = 0; i < n; i++) begin
        do c = any_cp(); while (c == CP_LF);
        send_guarded(c);
      end
      send_guarded(CP_LF);
    end else if (r < 62) begin
      n = $urandom_range(6, 1);
      for (i = 0; i < n; i++) send_guarded(plain_cp());
    end else if (r < 72) begin
      send_guarded(CP_SQUOTE);
      n = $urandom_range(5);
      for (i = 0; i < n; i++) send_guarded(text_cp(1'b0));
      send_guarded(CP_SQUOTE);
    end else begin
      send_guarded(CP_DQUOTE);
      n = $urandom_range(6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(2) == 0) send_escape();
        else send_guarded(text_cp(1'b1));
      end
      send_guarded(CP_DQUOTE);
    end
  endtask

  // Walk the lexer back to idle whatever it was in the middle of
  task automatic settle_lexer();
    while (lex != LEX_IDLE) begin
      case (lex)
        LEX_COMMENT: send_cp(CP_LF);
        LEX_QUOTED:  send_cp(in_dquote ? CP_DQUOTE : CP_SQUOTE);
        default:     send_cp(CP_SPACE);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A list, an ignored zero, the widest code point in a plain atom ended by a tab, a
  // comment holding a carriage return and closed by a line feed, and a vertical tab
  task automatic test_structure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_text("(");
    send_cp('0);
    send_text("a");
    send_cp(21'h10FFFF);
    send_cp(CP_TAB);
    send_text(";c");
    send_cp(CP_CR);
    send_cp(CP_LF);
    send_cp(CP_VT);
    send_text(")");
  endtask

  // Empty single-quoted atom, then a double-quoted one right behind its closing
  // quote: full unicode escape, short hex escape cut by a non-digit, unknown escape
  task automatic test_quoted();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_text("''\"\\u20ac\\x4g\\q\" ");
  endtask

  // Sink holds off for a long stretch while requests keep coming with no gaps,
  // so the internal queue fills and the block pushes back on its input
  task automatic test_backpressure();
    int i;
    tx_idle_on = 1'b0;
    hold_requests++;
    send_cp(CP_LPAREN);
    for (i = 0; i < 40; i++) send_cp(plain_cp());
    send_cp(CP_RPAREN);
    tx_idle_on = 1'b1;
  endtask

  // Random token stream; idling on either side switches on and off as it goes
  task automatic test_random_text();
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(19) == 0) begin
        tx_idle_on = 1'($urandom_range(1));
        rx_idle_on = 1'($urandom_range(1));
      end
      send_random_token();
    end
  endtask

  // Sticky error: one close more than was opened. Everything after it must stay silent.
  task automatic test_sticky_error();
    int i;
    settle_lexer();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (depth > 0) send_cp(CP_RPAREN);
    send_cp(CP_RPAREN);
    for (i = 0; i < 6; i++) send_cp(any_cp());
    send_cp(CP_LPAREN);
    send_cp(CP_RPAREN);
  endtask

  // ---------------------------------------------------------------------------
  // Event sink: checks every accepted event and drives ready
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : token_sink
    token_ev_t want;
    ev_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && ev_bus.valid && ev_bus.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("event_kind: expected none, got %0d", ev_bus.event_kind);
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("event_kind", want.kind, ev_bus.event_kind);
          check_field("atom_type", want.atype, ev_bus.atom_type);
          check_field("data_byte", want.data, ev_bus.data_byte);
          check_field("start_line", want.line, ev_bus.start_line);
          check_field("nest_level", want.nest, ev_bus.nest_level);
          check_field("fault_code", want.fault, ev_bus.fault_code);
          check_field("last", want.last, ev_bus.last);
        end
      end
      // a long hold-off asked for by a test wins over random stalls
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        rx_wait      = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        ev_bus.ready <= 1'b0;
        rx_wait--;
      end else if (rx_idle_on && $urandom_range(3) == 0) begin
        rx_wait = idle_gap();
        ev_bus.ready <= (rx_wait == 0);
      end else begin
        ev_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cp_bus.valid      = 1'b0;
    cp_bus.code_point = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_structure();
    test_quoted();
    test_backpressure();
    test_random_text();
    test_sticky_error();
    cp_bus.valid <= 1'b0;

    // everything owed must arrive, then a short quiet spell catches strays
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
